// ----- src/lpk_pkg.sv -----
// Shared constants, types and the kernel table for the log-polar column kernel.
// The kernel table is built by constant functions when the design is elaborated.
// No dependencies.
package lpk_pkg;

    // Block configuration
    localparam int MAX_LEN          = 1024;
    localparam int SAMPLE_BITS      = 16;
    localparam int KERNEL_FRAC_BITS = 15;

    // Port field widths
    localparam int SAMPLE_W    = 16;
    localparam int SPLIT_W     = 11;
    localparam int S_TDATA_W   = 32;
    localparam int MAG_W       = 43;
    localparam int M_TDATA_W   = 88;

    // Datapath widths
    localparam int IDX_W       = $clog2(MAX_LEN);
    localparam int POS_W       = $clog2(MAX_LEN + 1);
    localparam int KHALF_W     = 16;
    localparam int KERNEL_W    = 2 * KHALF_W;
    localparam int PROD_W      = KHALF_W + SAMPLE_BITS + 1;
    localparam int ACC_W       = 42;
    localparam int HALF_W      = ACC_W / 2;
    localparam int RAD_W       = 2 * MAG_W;
    localparam int REM_W       = MAG_W + 3;

    // Queue between the front end and the multiply-accumulate pipeline
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Table construction: unsigned fixed point with 58 fraction bits
    localparam int          FXB           = 58;
    localparam logic [63:0] FX_ONE        = 64'd1 << FXB;
    localparam int          KSH           = FXB - KERNEL_FRAC_BITS;
    localparam logic [63:0] KLIM          = (64'd1 << KERNEL_FRAC_BITS) - 64'd1;
    localparam int          TAYLOR_TERMS  = 20;

    typedef logic [KERNEL_W-1:0]               kernel_entry_t;
    typedef kernel_entry_t [MAX_LEN-1:0]       kernel_table_t;

    // One classified sample on its way to the accumulators
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [IDX_W-1:0]       idx;
        logic                   is_right;
        logic                   term_valid;
        logic                   last;
    } term_t;

    // Final column sums handed to the magnitude unit
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] right_re;
        logic signed [ACC_W-1:0] right_im;
        logic signed [ACC_W-1:0] left_re;
        logic signed [ACC_W-1:0] left_im;
    } sums_t;

    typedef enum logic [1:0] {
        MAG_IDLE,
        MAG_SQUARE,
        MAG_ROOT,
        MAG_OUT
    } mag_state_t;

    // Truncated fixed-point product.
    function automatic logic [63:0] fx_mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[FXB +: 64];
    endfunction

    // Truncating long division, one quotient bit per pass.
    function automatic logic [63:0] fx_long_div(input logic [63:0] num,
                                                input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atanh(1/n) when hyperbolic is set, atan(1/n) otherwise.
    function automatic logic [63:0] fx_arc_inv(input logic [63:0] n, input logic hyperbolic);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] zp;
        logic [63:0] sum;
        logic [63:0] term;
        logic        done;
        z    = fx_long_div(FX_ONE, n);
        z2   = fx_mulq(z, z);
        zp   = z;
        sum  = z;
        done = 1'b0;
        for (int k = 1; k < 64; k++)
        begin
            if (!done)
            begin
                zp = fx_mulq(zp, z2);
                if (zp == 64'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    term = fx_long_div(zp, 64'(2 * k + 1));
                    if (hyperbolic || !k[0])
                    begin
                        sum = sum + term;
                    end
                    else
                    begin
                        sum = sum - term;
                    end
                end
            end
        end
        return sum;
    endfunction

    // Round half away from zero to the kernel format, saturating the magnitude.
    function automatic logic [KHALF_W-1:0] fx_to_kernel(input logic [63:0] v);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? (64'd0 - v) : v;
        q   = (mag + (64'd1 << (KSH - 1))) >> KSH;
        if (q > KLIM)
        begin
            q = KLIM;
        end
        if (v[63])
        begin
            q = 64'd0 - q;
        end
        return q[KHALF_W-1:0];
    endfunction

    // Entry i holds cos and sin of 3 ln(i + 1); real half in the low bits.
    function automatic kernel_table_t build_kernel_table();
        kernel_table_t tbl;
        logic [63:0]   pi;
        logic [63:0]   two_pi;
        logic [63:0]   half_pi;
        logic [63:0]   ln_r;
        logic [63:0]   a;
        logic [63:0]   q;
        logic [63:0]   x;
        logic [63:0]   x2;
        logic [63:0]   tc;
        logic [63:0]   ts;
        logic [63:0]   c;
        logic [63:0]   s;
        logic [63:0]   cr;
        logic [63:0]   sr;
        pi      = (fx_arc_inv(64'd5, 1'b0) << 4) - (fx_arc_inv(64'd239, 1'b0) << 2);
        two_pi  = pi << 1;
        half_pi = pi >> 1;
        ln_r    = '0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (i > 0)
            begin
                ln_r = ln_r + (fx_arc_inv(64'(2 * i + 1), 1'b1) << 1);
            end
            a  = 64'd3 * ln_r;
            a  = a - fx_long_div(a, two_pi) * two_pi;
            q  = fx_long_div(a, half_pi);
            x  = a - q * half_pi;
            x2 = fx_mulq(x, x);
            tc = FX_ONE;
            ts = x;
            c  = tc;
            s  = ts;
            for (int n = 1; n <= TAYLOR_TERMS; n++)
            begin
                tc = fx_long_div(fx_mulq(tc, x2), 64'((2 * n - 1) * (2 * n)));
                ts = fx_long_div(fx_mulq(ts, x2), 64'((2 * n) * (2 * n + 1)));
                if (n[0])
                begin
                    c = c - tc;
                    s = s - ts;
                end
                else
                begin
                    c = c + tc;
                    s = s + ts;
                end
            end
            case (q[1:0])
                2'd0:
                begin
                    cr = c;
                    sr = s;
                end
                2'd1:
                begin
                    cr = 64'd0 - s;
                    sr = c;
                end
                2'd2:
                begin
                    cr = 64'd0 - c;
                    sr = 64'd0 - s;
                end
                default:
                begin
                    cr = s;
                    sr = 64'd0 - c;
                end
            endcase
            tbl[i] = {fx_to_kernel(sr), fx_to_kernel(cr)};
        end
        return tbl;
    endfunction

    localparam kernel_table_t KERNEL_TABLE = build_kernel_table();

endpackage

// ----- src/lpk_front.sv -----
// Input side: takes samples, tracks the position in the column and works out
// which sum and which kernel entry each sample feeds. Uses lpk_pkg.
module lpk_front
    import lpk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SPLIT_W-1:0]  split_point,
    input  logic                last_sample,
    input  logic                fifo_full,
    output logic                push,
    output term_t               push_data
);

    localparam int CMP_W = SPLIT_W + 1;

    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] split_ext;
    logic [CMP_W-1:0] right_idx;
    logic [CMP_W-1:0] left_idx;
    logic             in_range;
    logic             is_right;

    assign s_tready  = !fifo_full;
    assign push      = s_tvalid && s_tready;

    assign in_range  = position_reg < POS_W'(MAX_LEN);
    assign pos_ext   = CMP_W'(position_reg);
    assign split_ext = CMP_W'(split_point);
    assign is_right  = pos_ext >= split_ext;
    assign right_idx = pos_ext - split_ext;
    assign left_idx  = split_ext - pos_ext - CMP_W'(1);

    // Left terms that reach past the end of the table are dropped, as are samples past the table length.
    always_comb
    begin
        push_data.sample     = sample[SAMPLE_BITS-1:0];
        push_data.is_right   = is_right;
        push_data.term_valid = in_range && (is_right || (left_idx < CMP_W'(MAX_LEN)));
        push_data.idx        = is_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
        push_data.last       = last_sample;
    end

    always_comb
    begin
        position_next = position_reg;
        if (push)
        begin
            if (last_sample)
            begin
                position_next = '0;
            end
            else if (in_range)
            begin
                position_next = position_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else
        begin
            position_reg <= position_next;
        end
    end

endmodule

// ----- src/lpk_fifo.sv -----
// Short queue of classified samples between the front end and the
// multiply-accumulate pipeline. Uses lpk_pkg.
module lpk_fifo
    import lpk_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  term_t push_data,
    input  logic  pop,
    output term_t pop_data,
    output logic  full,
    output logic  empty
);

    term_t                 entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign full     = count_reg == FIFO_CNT_W'(FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/lpk_mac.sv -----
// Back-end pipeline: kernel ROM read, complex multiply and the four column
// accumulators; hands the sums of a finished column on. Uses lpk_pkg.
module lpk_mac
    import lpk_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fifo_empty,
    input  term_t fifo_data,
    output logic  fifo_pop,
    input  logic  mag_ready,
    output sums_t handoff
);

    // Stage A: ROM lookup
    logic                     a_valid_reg;
    term_t                    a_term_reg;
    kernel_entry_t            rom_reg;
    // Stage B: products
    logic                     b_valid_reg;
    logic                     b_right_reg;
    logic                     b_term_valid_reg;
    logic                     b_last_reg;
    logic signed [PROD_W-1:0] b_prod_re_reg;
    logic signed [PROD_W-1:0] b_prod_im_reg;
    // Accumulators
    logic signed [ACC_W-1:0]  right_re_reg;
    logic signed [ACC_W-1:0]  right_im_reg;
    logic signed [ACC_W-1:0]  left_re_reg;
    logic signed [ACC_W-1:0]  left_im_reg;

    logic signed [ACC_W-1:0]   term_re;
    logic signed [ACC_W-1:0]   term_im;
    logic signed [ACC_W-1:0]   right_re_next;
    logic signed [ACC_W-1:0]   right_im_next;
    logic signed [ACC_W-1:0]   left_re_next;
    logic signed [ACC_W-1:0]   left_im_next;
    logic signed [KHALF_W-1:0] k_re;
    logic signed [KHALF_W-1:0] k_im;
    logic signed [SAMPLE_BITS:0] samp_s;
    logic                      add_right;
    logic                      add_left;
    logic                      column_end;
    logic                      advance;

    // The pipeline only stops when a column end waits for the magnitude unit.
    assign column_end = b_valid_reg && b_last_reg;
    assign advance    = !(column_end && !mag_ready);
    assign fifo_pop   = advance && !fifo_empty;

    assign k_re   = rom_reg[KHALF_W-1:0];
    assign k_im   = rom_reg[KERNEL_W-1:KHALF_W];
    assign samp_s = {1'b0, a_term_reg.sample};

    assign term_re   = {{(ACC_W - PROD_W){b_prod_re_reg[PROD_W-1]}}, b_prod_re_reg};
    assign term_im   = {{(ACC_W - PROD_W){b_prod_im_reg[PROD_W-1]}}, b_prod_im_reg};
    assign add_right = b_valid_reg && b_term_valid_reg && b_right_reg;
    assign add_left  = b_valid_reg && b_term_valid_reg && !b_right_reg;

    assign right_re_next = right_re_reg + (add_right ? term_re : '0);
    assign right_im_next = right_im_reg + (add_right ? term_im : '0);
    assign left_re_next  = left_re_reg + (add_left ? term_re : '0);
    assign left_im_next  = left_im_reg + (add_left ? term_im : '0);

    always_comb
    begin
        handoff.valid    = column_end && mag_ready;
        handoff.right_re = right_re_next;
        handoff.right_im = right_im_next;
        handoff.left_re  = left_re_next;
        handoff.left_im  = left_im_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            right_re_reg <= '0;
            right_im_reg <= '0;
            left_re_reg  <= '0;
            left_im_reg  <= '0;
        end
        else if (advance)
        begin
            a_valid_reg <= fifo_pop;
            b_valid_reg <= a_valid_reg;
            if (column_end)
            begin
                right_re_reg <= '0;
                right_im_reg <= '0;
                left_re_reg  <= '0;
                left_im_reg  <= '0;
            end
            else
            begin
                right_re_reg <= right_re_next;
                right_im_reg <= right_im_next;
                left_re_reg  <= left_re_next;
                left_im_reg  <= left_im_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_term_reg       <= fifo_data;
            rom_reg          <= KERNEL_TABLE[fifo_data.idx];
            b_right_reg      <= a_term_reg.is_right;
            b_term_valid_reg <= a_term_reg.term_valid;
            b_last_reg       <= a_term_reg.last;
            b_prod_re_reg    <= k_re * samp_s;
            b_prod_im_reg    <= k_im * samp_s;
        end
    end

endmodule

// ----- src/lpk_mag.sv -----
// Magnitude unit: squares the column sums from 21-bit partial products, takes
// both floor square roots one bit per cycle and holds the result. Uses lpk_pkg.
module lpk_mag
    import lpk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  sums_t            handoff,
    output logic             ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [MAG_W-1:0] right_magnitude,
    output logic [MAG_W-1:0] left_magnitude
);

    localparam int SQ_STEPS   = 16;
    localparam int SQ_CNT_W   = $clog2(SQ_STEPS + 1);
    localparam int ROOT_CNT_W = $clog2(MAG_W);

    localparam logic [1:0] PART_HI_HI = 2'd0;
    localparam logic [1:0] PART_LO_LO = 2'd3;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
    } root_step_t;

    mag_state_t              state_reg;
    mag_state_t              state_next;
    logic [SQ_CNT_W-1:0]     step_reg;
    logic [ROOT_CNT_W-1:0]   root_cnt_reg;
    logic                    prod_en_reg;
    logic [ACC_W-1:0]        abs_reg [4];
    logic [2*HALF_W-1:0]     prod_reg;
    logic [1:0]              prod_part_reg;
    logic                    prod_left_reg;
    logic [RAD_W-1:0]        energy_r_reg;
    logic [RAD_W-1:0]        energy_l_reg;
    logic [REM_W-1:0]        rem_r_reg;
    logic [REM_W-1:0]        rem_l_reg;
    logic [MAG_W-1:0]        root_r_reg;
    logic [MAG_W-1:0]        root_l_reg;

    logic                    load;
    logic                    issue;
    logic                    root_run;
    logic [1:0]              op_sel;
    logic [1:0]              part_sel;
    logic [ACC_W-1:0]        operand;
    logic [HALF_W-1:0]       mul_a;
    logic [HALF_W-1:0]       mul_b;
    logic [RAD_W-1:0]        prod_shifted;
    root_step_t              step_r;
    root_step_t              step_l;

    function automatic logic [ACC_W-1:0] abs_acc(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    endfunction

    // One digit of the restoring square root.
    function automatic root_step_t sqrt_step(input logic [REM_W-1:0] rem,
                                             input logic [MAG_W-1:0] root,
                                             input logic [1:0]       digits);
        root_step_t       res;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        shifted = {rem[REM_W-3:0], digits};
        trial   = REM_W'({root, 2'b01});
        if (shifted >= trial)
        begin
            res.rem  = shifted - trial;
            res.root = {root[MAG_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = shifted;
            res.root = {root[MAG_W-2:0], 1'b0};
        end
        return res;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MAG_IDLE:
            begin
                if (handoff.valid)
                begin
                    state_next = MAG_SQUARE;
                end
            end
            MAG_SQUARE:
            begin
                if (step_reg == SQ_CNT_W'(SQ_STEPS))
                begin
                    state_next = MAG_ROOT;
                end
            end
            MAG_ROOT:
            begin
                if (root_cnt_reg == ROOT_CNT_W'(MAG_W - 1))
                begin
                    state_next = MAG_OUT;
                end
            end
            MAG_OUT:
            begin
                if (m_tready)
                begin
                    state_next = MAG_IDLE;
                end
            end
            default:
            begin
                state_next = MAG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ready    = 1'b0;
        load     = 1'b0;
        issue    = 1'b0;
        root_run = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            MAG_IDLE:
            begin
                ready = 1'b1;
                load  = handoff.valid;
            end
            MAG_SQUARE:
            begin
                issue = step_reg < SQ_CNT_W'(SQ_STEPS);
            end
            MAG_ROOT:
            begin
                root_run = 1'b1;
            end
            MAG_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    // Steps walk four operands, each as four 21 by 21 partial products.
    assign op_sel   = step_reg[3:2];
    assign part_sel = step_reg[1:0];
    assign operand  = abs_reg[op_sel];
    assign mul_a    = part_sel[1] ? operand[HALF_W-1:0] : operand[ACC_W-1:HALF_W];
    assign mul_b    = part_sel[0] ? operand[HALF_W-1:0] : operand[ACC_W-1:HALF_W];

    always_comb
    begin
        case (prod_part_reg)
            PART_HI_HI: prod_shifted = RAD_W'(prod_reg) << (2 * HALF_W);
            PART_LO_LO: prod_shifted = RAD_W'(prod_reg);
            default:    prod_shifted = RAD_W'(prod_reg) << HALF_W;
        endcase
    end

    assign step_r = sqrt_step(rem_r_reg, root_r_reg, energy_r_reg[RAD_W-1 -: 2]);
    assign step_l = sqrt_step(rem_l_reg, root_l_reg, energy_l_reg[RAD_W-1 -: 2]);

    assign right_magnitude = root_r_reg;
    assign left_magnitude  = root_l_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= MAG_IDLE;
            step_reg     <= '0;
            root_cnt_reg <= '0;
            prod_en_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            prod_en_reg <= issue;
            if (load)
            begin
                step_reg     <= '0;
                root_cnt_reg <= '0;
            end
            else
            begin
                if (state_reg == MAG_SQUARE)
                begin
                    step_reg <= step_reg + SQ_CNT_W'(1);
                end
                if (root_run)
                begin
                    root_cnt_reg <= root_cnt_reg + ROOT_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            abs_reg[0]   <= abs_acc(handoff.right_re);
            abs_reg[1]   <= abs_acc(handoff.right_im);
            abs_reg[2]   <= abs_acc(handoff.left_re);
            abs_reg[3]   <= abs_acc(handoff.left_im);
            energy_r_reg <= '0;
            energy_l_reg <= '0;
            rem_r_reg    <= '0;
            rem_l_reg    <= '0;
            root_r_reg   <= '0;
            root_l_reg   <= '0;
        end
        if (issue)
        begin
            prod_reg      <= {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
            prod_part_reg <= part_sel;
            prod_left_reg <= op_sel[1];
        end
        if (prod_en_reg)
        begin
            if (prod_left_reg)
            begin
                energy_l_reg <= energy_l_reg + prod_shifted;
            end
            else
            begin
                energy_r_reg <= energy_r_reg + prod_shifted;
            end
        end
        if (root_run)
        begin
            energy_r_reg <= energy_r_reg << 2;
            energy_l_reg <= energy_l_reg << 2;
            rem_r_reg    <= step_r.rem;
            rem_l_reg    <= step_l.rem;
            root_r_reg   <= step_r.root;
            root_l_reg   <= step_l.root;
        end
    end

endmodule

// ----- src/log_polar_kernel_split_magnitude.sv -----
// Log-polar kernel column transform with a split point. Samples of one column
// stream in one per transaction; each is weighted by the complex kernel
// exp(j 3 ln r) and added to the right sum (at or past the split) or the left
// sum, and the last sample of a column yields one result holding the floor
// magnitudes of both sums in Q.15 scale. The input side takes one sample per
// cycle while the four-entry queue it feeds is not full; a three-stage ROM,
// multiply and accumulate pipeline drains it at one sample per cycle while no
// column end waits for the magnitude unit. After the last sample the magnitude
// unit forms the squares from partial products and then the bit-serial square
// roots; a new column end waits while the previous result is still in the
// magnitude unit or not yet taken. Uses lpk_pkg, lpk_front, lpk_fifo, lpk_mac,
// lpk_mag.
module log_polar_kernel_split_magnitude
    import lpk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sample[15:0], split_point[26:16], zero pad
    input  logic                 s_tlast,   // last_sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // right_magnitude[42:0], left_magnitude[85:43]
);

    logic             fifo_push;
    logic             fifo_pop;
    logic             fifo_full;
    logic             fifo_empty;
    term_t            fifo_in;
    term_t            fifo_out;
    logic             mag_ready;
    sums_t            handoff;
    logic [MAG_W-1:0] right_magnitude;
    logic [MAG_W-1:0] left_magnitude;

    lpk_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .sample      (s_tdata[SAMPLE_W-1:0]),
        .split_point (s_tdata[SAMPLE_W +: SPLIT_W]),
        .last_sample (s_tlast),
        .fifo_full   (fifo_full),
        .push        (fifo_push),
        .push_data   (fifo_in)
    );

    lpk_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_in),
        .pop       (fifo_pop),
        .pop_data  (fifo_out),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    lpk_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_data  (fifo_out),
        .fifo_pop   (fifo_pop),
        .mag_ready  (mag_ready),
        .handoff    (handoff)
    );

    lpk_mag u_mag (
        .clk             (clk),
        .rst_n           (rst_n),
        .handoff         (handoff),
        .ready           (mag_ready),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .right_magnitude (right_magnitude),
        .left_magnitude  (left_magnitude)
    );

    assign m_tdata = {{(M_TDATA_W - 2 * MAG_W){1'b0}}, left_magnitude, right_magnitude};

`ifndef SYNTHESIS
    // Column sums are only handed over when the magnitude unit can take them.
    assert property (@(posedge clk) disable iff (!rst_n)
        handoff.valid |-> mag_ready)
        else $error("column sums handed over while magnitude unit busy");

    // A result is delivered once: the unit leaves its output state afterwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result presented again after its transaction");

    // An accepted sample is in the queue on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !fifo_empty)
        else $error("accepted sample missing from queue");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for log_polar_kernel_split_magnitude.
// Streams sample columns into the block and predicts both magnitudes with its own kernel table.
// Depends on lpk_pkg for port widths and on the block itself; reads no files.
module tb_top;
    import lpk_pkg::*;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // sample[15:0], split_point[26:16], zero pad
    logic                 s_tlast  = 1'b0;  // last_sample
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // right_magnitude[42:0], left_magnitude[85:43]

    localparam longint unsigned FX_UNIT = 64'd1 << 58;

    typedef struct {
        logic [MAG_W-1:0] right_mag;
        logic [MAG_W-1:0] left_mag;
    } magnitude_pair_t;

    // Kernel table and column sums kept by the predictor.
    int     kern_re [MAX_LEN];
    int     kern_im [MAX_LEN];
    int     col_position;
    longint rsum_re;
    longint rsum_im;
    longint lsum_re;
    longint lsum_im;

    magnitude_pair_t pending_magnitudes[$];

    bit          idling_on = 1'b0;
    int unsigned ready_hold = 0;
    int unsigned ready_draw;
    int unsigned mismatch_count = 0;
    int unsigned samples_sent = 0;
    int unsigned columns_sent = 0;
    int unsigned results_checked = 0;

    log_polar_kernel_split_magnitude dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // Kernel table arithmetic: unsigned 58-bit fraction, truncating.
    // ---------------------------------------------------------------
    function automatic longint unsigned fx_product(input longint unsigned a,
                                                   input longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[121:58];
    endfunction

    // Series for atanh(1/n) or atan(1/n), stopped once the power term vanishes.
    function automatic longint inverse_arc(input longint unsigned n, input bit hyperbolic);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned zp;
        longint unsigned k;
        longint          acc;
        z   = FX_UNIT / n;
        z2  = fx_product(z, z);
        zp  = z;
        acc = longint'(z);
        for (k = 1; k < 64; k++)
        begin
            zp = fx_product(zp, z2);
            if (zp == 0)
                break;
            if (hyperbolic || k[0] == 1'b0)
                acc += longint'(zp / (2 * k + 1));
            else
                acc -= longint'(zp / (2 * k + 1));
        end
        return acc;
    endfunction

    // Round half away from zero to Q1.15 and saturate the magnitude.
    function automatic int round_to_q15(input longint v);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? longint'(0) - v : v;
        q   = (mag + (64'd1 << 42)) >> 43;
        if (q > 32767)
            q = 32767;
        return (v < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic void build_predictor_kernel();
        longint unsigned pi_fx;
        longint unsigned two_pi;
        longint unsigned half_pi;
        longint unsigned ln_r;
        longint unsigned ang;
        longint unsigned quad;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint unsigned n;
        longint          c;
        longint          s;
        longint          cr;
        longint          sr;
        pi_fx   = longint'(16 * inverse_arc(5, 1'b0) - 4 * inverse_arc(239, 1'b0));
        two_pi  = 2 * pi_fx;
        half_pi = pi_fx / 2;
        ln_r    = 0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (i > 0)
                ln_r += 2 * longint'(inverse_arc(2 * (i + 1) - 1, 1'b1));
            ang  = (3 * ln_r) % two_pi;
            quad = ang / half_pi;
            x    = ang - quad * half_pi;
            x2   = fx_product(x, x);
            tc   = FX_UNIT;
            ts   = x;
            c    = longint'(tc);
            s    = longint'(ts);
            for (n = 1; n <= 20; n++)
            begin
                tc = fx_product(tc, x2) / ((2 * n - 1) * (2 * n));
                ts = fx_product(ts, x2) / ((2 * n) * (2 * n + 1));
                if (n[0])
                begin
                    c -= longint'(tc);
                    s -= longint'(ts);
                end
                else
                begin
                    c += longint'(tc);
                    s += longint'(ts);
                end
            end
            case (quad[1:0])
                2'd0:
                begin
                    cr = c;
                    sr = s;
                end
                2'd1:
                begin
                    cr = -s;
                    sr = c;
                end
                2'd2:
                begin
                    cr = -c;
                    sr = -s;
                end
                default:
                begin
                    cr = s;
                    sr = -c;
                end
            endcase
            kern_re[i] = round_to_q15(cr);
            kern_im[i] = round_to_q15(sr);
        end
    endfunction

    // Floor square root of re^2 + im^2, built one result bit at a time.
    function automatic logic [MAG_W-1:0] floor_magnitude(input longint re, input longint im);
        longint unsigned ar;
        longint unsigned ai;
        longint unsigned root;
        longint unsigned cand;
        logic [127:0]    radicand;
        ar       = (re < 0) ? longint'(0) - re : re;
        ai       = (im < 0) ? longint'(0) - im : im;
        radicand = {64'd0, ar} * {64'd0, ar} + {64'd0, ai} * {64'd0, ai};
        root     = 0;
        for (int b = MAG_W - 1; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= radicand)
                root = cand;
        end
        return root[MAG_W-1:0];
    endfunction

    function automatic void clear_column();
        col_position = 0;
        rsum_re      = 0;
        rsum_im      = 0;
        lsum_re      = 0;
        lsum_im      = 0;
    endfunction

    // Adds one accepted sample into the column sums and queues the magnitudes on the last one.
    function automatic void fold_sample_into_sums(input logic [SAMPLE_W-1:0] smp,
                                                  input logic [SPLIT_W-1:0] split,
                                                  input bit last);
        longint          value;
        int              idx;
        magnitude_pair_t pair;
        value = longint'(smp);
        if (col_position < MAX_LEN)
        begin
            if (col_position >= int'(split))
            begin
                idx = col_position - int'(split);
                rsum_re += longint'(kern_re[idx]) * value;
                rsum_im += longint'(kern_im[idx]) * value;
            end
            else
            begin
                // Entries past the end of the table contribute nothing.
                idx = int'(split) - 1 - col_position;
                if (idx < MAX_LEN)
                begin
                    lsum_re += longint'(kern_re[idx]) * value;
                    lsum_im += longint'(kern_im[idx]) * value;
                end
            end
            col_position++;
        end
        if (last)
        begin
            pair.right_mag = floor_magnitude(rsum_re, rsum_im);
            pair.left_mag  = floor_magnitude(lsum_re, lsum_im);
            pending_magnitudes.push_back(pair);
            clear_column();
        end
    endfunction

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic [SPLIT_W-1:0] split,
                               input bit last);
        int unsigned gap;
        gap = idling_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({split, smp});
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        fold_sample_into_sums(smp, split, last);
        samples_sent++;
        if (last)
            columns_sent++;
    endtask

    // Holds the input side quiet until every queued result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_magnitudes.size() > 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ---------------------------------------------------------------
    task automatic check_result(input logic [M_TDATA_W-1:0] data);
        magnitude_pair_t  want;
        logic [MAG_W-1:0] got_right;
        logic [MAG_W-1:0] got_left;
        got_right = data[MAG_W-1:0];
        got_left  = data[2*MAG_W-1:MAG_W];
        results_checked++;
        if (pending_magnitudes.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("ERROR: unexpected result right=%0d left=%0d", got_right, got_left);
        end
        else
        begin
            want = pending_magnitudes.pop_front();
            if (got_right !== want.right_mag || got_left !== want.left_mag)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: result %0d right exp %0d got %0d, left exp %0d got %0d",
                             results_checked, want.right_mag, got_right,
                             want.left_mag, got_left);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            check_result(m_tdata);
        if (!idling_on)
        begin
            ready_hold <= 0;
            m_tready   <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready   <= (ready_hold == 1);
        end
        else if (m_tvalid && m_tready)
        begin
            ready_draw = $urandom_range(0, 7);
            ready_hold <= ready_draw;
            m_tready   <= (ready_draw == 0);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_columns();
        idling_on = 1'b1;
        // One-sample columns: right entry 0, left entry 0, and a left index off the table.
        push_sample(16'hFFFF, 11'd0, 1'b1);
        push_sample(16'hFFFF, 11'd1, 1'b1);
        push_sample(16'h0000, 11'd2047, 1'b1);
        // Split at the largest column length reaches the last table entries on the left.
        push_sample(16'hFFFF, 11'd1024, 1'b0);
        push_sample(16'hFFFF, 11'd1024, 1'b1);
        // First left index lands just past the table and is dropped.
        push_sample(16'hFFFF, 11'd1025, 1'b0);
        push_sample(16'hFFFF, 11'd1025, 1'b1);
        // Split lies beyond the end of a short column.
        push_sample(16'h1234, 11'd10, 1'b0);
        push_sample(16'hABCD, 11'd10, 1'b0);
        push_sample(16'h8000, 11'd10, 1'b1);
        // Split point moves from sample to sample.
        push_sample(16'h7FFF, 11'd0, 1'b0);
        push_sample(16'h5555, 11'd3, 1'b0);
        push_sample(16'hAAAA, 11'd1, 1'b0);
        push_sample(16'hFFFF, 11'd2, 1'b1);
        // Both sums active, no idling on either side.
        idling_on = 1'b0;
        push_sample(16'h8000, 11'd2, 1'b0);
        push_sample(16'h7FFF, 11'd2, 1'b0);
        push_sample(16'hFFFF, 11'd2, 1'b0);
        push_sample(16'h0001, 11'd2, 1'b1);
        drain_results();
    endtask

    // Runs past the table length; the extra samples must add nothing.
    task automatic test_overlong_column();
        idling_on = 1'b1;
        for (int k = 0; k < MAX_LEN + 6; k++)
            push_sample(SAMPLE_W'($urandom), 11'd0, k == MAX_LEN + 5);
    endtask

    task automatic test_random_columns(input int item_budget);
        int                   len;
        int                   mode;
        int                   base_split;
        int                   sent;
        bit                   paused;
        logic [SPLIT_W-1:0]   split;
        logic [SAMPLE_W-1:0]  smp;
        sent   = 0;
        paused = 1'b0;
        while (sent < item_budget)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 6)
                len = $urandom_range(1, 16);
            else if (mode < 9)
                len = $urandom_range(17, 64);
            else
                len = $urandom_range(65, 300);
            mode = $urandom_range(0, 19);
            if (mode < 14)
                base_split = $urandom_range(0, len);
            else if (mode < 17)
                base_split = $urandom_range(0, MAX_LEN);
            else
                base_split = $urandom_range(0, 2047);
            idling_on = ($urandom_range(0, 4) != 0);
            for (int k = 0; k < len; k++)
            begin
                split = (mode == 19) ? SPLIT_W'($urandom_range(0, len)) : SPLIT_W'(base_split);
                if ($urandom_range(0, 9) == 0)
                    smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                else
                    smp = SAMPLE_W'($urandom);
                push_sample(smp, split, k == len - 1);
            end
            sent += len;
            if (!paused && sent >= item_budget / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        build_predictor_kernel();
        clear_column();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_columns();
        test_overlong_column();
        test_random_columns(500);

        drain_results();
        repeat (200) @(posedge clk);
        if (pending_magnitudes.size() > 0)
        begin
            mismatch_count++;
            $display("ERROR: %0d results never arrived", pending_magnitudes.size());
        end
        $display("Covered %0d samples in %0d columns, %0d results checked, %0d mismatches.",
                 samples_sent, columns_sent, results_checked, mismatch_count);
        $display("Columns included one-sample, overlong, off-table and moving-split cases.");
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(12 * 1000000);
        $display("ERROR: run did not finish in time");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
